FILE: sv/assert_macros.svh
// assertion macros shared by the terminal rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition that must hold at every clock edge out of reset
`define TTCS_ASSERT(name, cond) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("ttcs assertion failed");

// implication checked in the same cycle
`define TTCS_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ttcs assertion failed");

`endif

FILE: sv/ttcs_pkg.sv
`timescale 1ns / 1ps
// types and constants shared by the text terminal blocks
package ttcs_pkg;

	// command field
	localparam logic CMD_PUT  = 1'b0;
	localparam logic CMD_READ = 1'b1;

	// control characters
	localparam logic [7:0] CHAR_NL = 8'h0A;
	localparam logic [7:0] CHAR_FF = 8'h0C;

	// cell written by a form feed
	localparam logic [15:0] CLEAR_CELL = 16'h0700;

	// configuration register indexes
	localparam int          CFG_IDX_W     = 3;
	localparam logic [2:0]  REG_FILL      = 3'd0;
	localparam logic [2:0]  REG_LEFT      = 3'd1;
	localparam logic [2:0]  REG_RIGHT     = 3'd2;
	localparam logic [2:0]  REG_UP        = 3'd3;
	localparam logic [2:0]  REG_DOWN      = 3'd4;

	// configuration reset values
	localparam logic [7:0] RST_FILL  = 8'd7;
	localparam logic [7:0] RST_LEFT  = 8'd17;
	localparam logic [7:0] RST_RIGHT = 8'd18;
	localparam logic [7:0] RST_UP    = 8'd19;
	localparam logic [7:0] RST_DOWN  = 8'd20;

	// operation classes decided by the front end
	localparam logic [2:0] OP_READ    = 3'd0;
	localparam logic [2:0] OP_NEWLINE = 3'd1;
	localparam logic [2:0] OP_FF      = 3'd2;
	localparam logic [2:0] OP_LEFT    = 3'd3;
	localparam logic [2:0] OP_RIGHT   = 3'd4;
	localparam logic [2:0] OP_UP      = 3'd5;
	localparam logic [2:0] OP_DOWN    = 3'd6;
	localparam logic [2:0] OP_PRINT   = 3'd7;

	// op queue sizing
	localparam int QDEPTH  = 4;
	localparam int Q_PTR_W = 2;
	localparam int Q_CNT_W = 3;

	typedef struct packed {
		logic       cmd;
		logic [7:0] char_byte;
		logic [7:0] char_color;
		logic       keep_color;
		logic [6:0] read_col;
		logic [4:0] read_row;
	} ttcs_in_t;

	typedef struct packed {
		logic [6:0]  cursor_col;
		logic [4:0]  cursor_row;
		logic [10:0] cursor_linear;
		logic [15:0] read_cell;
		logic        did_scroll;
		logic        did_clear;
	} ttcs_out_t;

	typedef struct packed {
		logic [2:0] kind;
		logic       in_range;
		logic [7:0] char_byte;
		logic [7:0] char_color;
		logic       keep_color;
		logic [6:0] read_col;
		logic [4:0] read_row;
	} ttcs_op_t;

	typedef struct packed {
		logic               full;
		logic               empty;
		logic [Q_CNT_W-1:0] count;
	} ttcs_q_stat_t;

	typedef struct packed {
		logic init_busy;
		logic busy;
	} ttcs_back_stat_t;

endpackage

FILE: sv/ttcs_front.sv
`timescale 1ns / 1ps
// front end: configuration registers and command classification
module ttcs_front import ttcs_pkg::*; #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data,
	input  ttcs_in_t             in_word,
	output ttcs_op_t             op,
	output logic [7:0]           fill_color
);

	logic [7:0] fill_q;
	logic [7:0] code_left_q;
	logic [7:0] code_right_q;
	logic [7:0] code_up_q;
	logic [7:0] code_down_q;
	logic       col_ok;
	logic       row_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q       <= RST_FILL;
			code_left_q  <= RST_LEFT;
			code_right_q <= RST_RIGHT;
			code_up_q    <= RST_UP;
			code_down_q  <= RST_DOWN;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FILL:  fill_q       <= cfg_data;
				REG_LEFT:  code_left_q  <= cfg_data;
				REG_RIGHT: code_right_q <= cfg_data;
				REG_UP:    code_up_q    <= cfg_data;
				REG_DOWN:  code_down_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign fill_color = fill_q;

	assign col_ok = ({1'b0, in_word.read_col} < 8'(COLUMNS));
	assign row_ok = ({2'b00, in_word.read_row} < 7'(ROWS));

	// newline and form feed win over the programmable codes
	always_comb begin
		op.in_range   = col_ok && row_ok;
		op.char_byte  = in_word.char_byte;
		op.char_color = in_word.char_color;
		op.keep_color = in_word.keep_color;
		op.read_col   = in_word.read_col;
		op.read_row   = in_word.read_row;
		if (in_word.cmd == CMD_READ)
			op.kind = OP_READ;
		else if (in_word.char_byte == CHAR_NL)
			op.kind = OP_NEWLINE;
		else if (in_word.char_byte == CHAR_FF)
			op.kind = OP_FF;
		else if (in_word.char_byte == code_left_q)
			op.kind = OP_LEFT;
		else if (in_word.char_byte == code_right_q)
			op.kind = OP_RIGHT;
		else if (in_word.char_byte == code_up_q)
			op.kind = OP_UP;
		else if (in_word.char_byte == code_down_q)
			op.kind = OP_DOWN;
		else
			op.kind = OP_PRINT;
	end

endmodule

FILE: sv/ttcs_queue.sv
`timescale 1ns / 1ps
// small fifo of classified ops between front and back
module ttcs_queue import ttcs_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  ttcs_op_t     push_op,
	input  logic         pop,
	output ttcs_op_t     head,
	output ttcs_q_stat_t stat
);

	ttcs_op_t           entry_q [QDEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
			if (push && !pop)
				count_q <= count_q + Q_CNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - Q_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_op;
	end

	assign head       = entry_q[rd_ptr_q];
	assign stat.full  = (count_q == Q_CNT_W'(QDEPTH));
	assign stat.empty = (count_q == '0);
	assign stat.count = count_q;

endmodule

FILE: sv/ttcs_back.sv
`timescale 1ns / 1ps
// back end: cell store, cursor, scroll and clear sequencer, result register
module ttcs_back import ttcs_pkg::*; #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic            clk,
	input  logic            arst_n,
	input  ttcs_op_t        op,
	input  logic            op_avail,
	output logic            op_pop,
	input  logic [7:0]      fill_color,
	output ttcs_back_stat_t stat,
	output logic            res_valid,
	input  logic            res_stall,
	output ttcs_out_t       res_word
);

	localparam int CW    = $clog2(COLUMNS);
	localparam int RW    = $clog2(ROWS);
	localparam int CELLS = ROWS * COLUMNS;
	localparam int AW    = $clog2(CELLS);

	localparam logic [2:0] ST_INIT   = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_EXEC   = 3'd2;
	localparam logic [2:0] ST_RDATA  = 3'd3;
	localparam logic [2:0] ST_SCROLL = 3'd4;
	localparam logic [2:0] ST_CLEAR  = 3'd5;
	localparam logic [2:0] ST_DONE   = 3'd6;

	logic [15:0]   mem [CELLS];
	logic [15:0]   rdata_q;

	logic [2:0]    state_q;
	ttcs_op_t      op_q;
	logic [CW-1:0] cur_col_q;
	logic [RW-1:0] cur_row_q;
	logic [RW-1:0] base_q;
	logic [AW-1:0] addr_q;
	logic [CW-1:0] cnt_q;
	logic [15:0]   cell_q;
	logic          scrolled_q;
	logic          cleared_q;
	logic          res_valid_q;
	ttcs_out_t     res_q;

	logic [AW-1:0] cur_addr;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] base_addr;
	logic [RW-1:0] base_next;
	logic [AW-1:0] lin;
	logic          col_last;
	logic          row_last;
	logic          do_adv;
	logic          do_nl;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [AW-1:0] mem_raddr;
	logic [15:0]   mem_wdata;

	// logical row to store address through the rotating row base
	function automatic logic [AW-1:0] phys_addr(
		input logic [RW-1:0] lrow,
		input logic [CW-1:0] col,
		input logic [RW-1:0] base
	);
		logic [RW:0] sum;
		sum = {1'b0, lrow} + {1'b0, base};
		if (sum >= (RW+1)'(ROWS))
			sum = sum - (RW+1)'(ROWS);
		return AW'(sum) * AW'(COLUMNS) + AW'(col);
	endfunction

	assign cur_addr  = phys_addr(cur_row_q, cur_col_q, base_q);
	assign rd_addr   = phys_addr(RW'(op_q.read_row), CW'(op_q.read_col), base_q);
	assign base_addr = AW'(base_q) * AW'(COLUMNS);
	assign base_next = (base_q == RW'(ROWS - 1)) ? '0 : base_q + RW'(1);
	assign lin       = AW'(cur_row_q) * AW'(COLUMNS) + AW'(cur_col_q);
	assign col_last  = (cur_col_q == CW'(COLUMNS - 1));
	assign row_last  = (cur_row_q == RW'(ROWS - 1));

	// printing a character moves the cursor the way newline does on a wrap
	assign do_adv = ((state_q == ST_EXEC) && (op_q.kind == OP_PRINT) && !op_q.keep_color) ||
			((state_q == ST_RDATA) && (op_q.kind == OP_PRINT));
	assign do_nl  = (state_q == ST_EXEC) && (op_q.kind == OP_NEWLINE);

	assign op_pop = (state_q == ST_IDLE) && op_avail && !res_valid_q;

	assign mem_raddr = (op_q.kind == OP_READ) ? rd_addr : cur_addr;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = addr_q;
		mem_wdata = '0;
		case (state_q)
			ST_INIT: begin
				mem_we = 1'b1;
			end
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_wdata = CLEAR_CELL;
			end
			ST_SCROLL: begin
				mem_we    = 1'b1;
				mem_wdata = {fill_color, 8'h00};
			end
			ST_EXEC: begin
				mem_we    = (op_q.kind == OP_PRINT) && !op_q.keep_color;
				mem_waddr = cur_addr;
				mem_wdata = {op_q.char_color, op_q.char_byte};
			end
			ST_RDATA: begin
				mem_we    = (op_q.kind == OP_PRINT);
				mem_waddr = cur_addr;
				mem_wdata = {rdata_q[15:8], op_q.char_byte};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[mem_raddr];
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			op_q        <= '0;
			cur_col_q   <= '0;
			cur_row_q   <= '0;
			base_q      <= '0;
			addr_q      <= '0;
			cnt_q       <= '0;
			cell_q      <= '0;
			scrolled_q  <= 1'b0;
			cleared_q   <= 1'b0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (res_valid_q && !res_stall)
				res_valid_q <= 1'b0;

			if (do_adv || do_nl) begin
				if (do_nl || col_last) begin
					cur_col_q <= '0;
					if (!row_last) begin
						cur_row_q <= cur_row_q + RW'(1);
						state_q   <= ST_DONE;
					end else begin
						// old top row becomes the blank bottom row
						addr_q     <= base_addr;
						cnt_q      <= '0;
						base_q     <= base_next;
						scrolled_q <= 1'b1;
						state_q    <= ST_SCROLL;
					end
				end else begin
					cur_col_q <= cur_col_q + CW'(1);
					state_q   <= ST_DONE;
				end
			end else begin
				case (state_q)
					ST_INIT: begin
						addr_q <= addr_q + AW'(1);
						if (addr_q == AW'(CELLS - 1)) begin
							addr_q  <= '0;
							state_q <= ST_IDLE;
						end
					end
					ST_IDLE: begin
						if (op_pop) begin
							op_q       <= op;
							cell_q     <= '0;
							scrolled_q <= 1'b0;
							cleared_q  <= 1'b0;
							state_q    <= ST_EXEC;
						end
					end
					ST_EXEC: begin
						case (op_q.kind)
							OP_READ:
								state_q <= op_q.in_range ? ST_RDATA : ST_DONE;
							OP_FF: begin
								addr_q    <= '0;
								base_q    <= '0;
								cur_col_q <= '0;
								cur_row_q <= '0;
								cleared_q <= 1'b1;
								state_q   <= ST_CLEAR;
							end
							OP_LEFT: begin
								if (cur_col_q != '0)
									cur_col_q <= cur_col_q - CW'(1);
								state_q <= ST_DONE;
							end
							OP_RIGHT: begin
								if (!col_last)
									cur_col_q <= cur_col_q + CW'(1);
								state_q <= ST_DONE;
							end
							OP_UP: begin
								if (cur_row_q != '0)
									cur_row_q <= cur_row_q - RW'(1);
								state_q <= ST_DONE;
							end
							OP_DOWN: begin
								if (!row_last)
									cur_row_q <= cur_row_q + RW'(1);
								state_q <= ST_DONE;
							end
							OP_PRINT:
								// only the keep-color case reaches here
								state_q <= ST_RDATA;
							default:
								state_q <= ST_DONE;
						endcase
					end
					ST_RDATA: begin
						cell_q  <= rdata_q;
						state_q <= ST_DONE;
					end
					ST_SCROLL: begin
						addr_q <= addr_q + AW'(1);
						cnt_q  <= cnt_q + CW'(1);
						if (cnt_q == CW'(COLUMNS - 1))
							state_q <= ST_DONE;
					end
					ST_CLEAR: begin
						addr_q <= addr_q + AW'(1);
						if (addr_q == AW'(CELLS - 1))
							state_q <= ST_DONE;
					end
					ST_DONE: begin
						res_valid_q         <= 1'b1;
						res_q.cursor_col    <= 7'(cur_col_q);
						res_q.cursor_row    <= 5'(cur_row_q);
						res_q.cursor_linear <= 11'(lin);
						res_q.read_cell     <= cell_q;
						res_q.did_scroll    <= scrolled_q;
						res_q.did_clear     <= cleared_q;
						state_q             <= ST_IDLE;
					end
					default:
						state_q <= ST_IDLE;
				endcase
			end
		end
	end

	assign stat.init_busy = (state_q == ST_INIT);
	assign stat.busy      = (state_q != ST_INIT) && (state_q != ST_IDLE);
	assign res_valid      = res_valid_q;
	assign res_word       = res_q;

endmodule

FILE: sv/text_terminal_cursor_scroll_top.sv
`timescale 1ns / 1ps
// top level of the character-cell text terminal
//
// usage:
// - in channel (in_valid, in_stall, in_word) takes one word per command: a put of
//   one byte (printable, newline, form feed or a cursor code) or a read of one cell
// - out channel (out_valid, out_stall, out_word) returns one word per command with
//   the cursor after it, the read cell and scroll/clear flags, in command order
// - cfg channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes the fill color
//   and the four cursor codes; ready is always high, write only while idle
// - sequence: a popped op goes through EXEC and DONE for moves, newlines without
//   scroll, off-screen reads and plain prints, through EXEC, RDATA and DONE for
//   on-screen reads and keep-color prints; a scroll adds SCROLL to blank the new
//   bottom row of COLUMNS cells, a form feed adds CLEAR to rewrite every cell
// - the back end finishes one command before it pops the next; a four-deep op
//   queue lets the input run ahead
// - after reset all ROWS*COLUMNS cells are swept to zero, with in_stall high
// - a stalled result holds in the output register while the queue keeps filling;
//   in_stall rises once the queue is full
`include "assert_macros.svh"
module text_terminal_cursor_scroll_top import ttcs_pkg::*; #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  ttcs_in_t             in_word,
	output logic                 out_valid,
	input  logic                 out_stall,
	output ttcs_out_t            out_word,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data
);

	ttcs_op_t        front_op;
	ttcs_op_t        head_op;
	ttcs_q_stat_t    q_stat;
	ttcs_back_stat_t back_stat;
	logic [7:0]      fill_color;
	logic            push;
	logic            pop;

	// register writes are always taken
	assign cfg_ready = 1'b1;

	// hold off input while the queue is full or the store is being swept
	assign in_stall = q_stat.full || back_stat.init_busy;
	assign push     = in_valid && !in_stall;

	// classify the incoming byte against the programmed codes
	ttcs_front #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_word    (in_word),
		.op         (front_op),
		.fill_color (fill_color)
	);

	// decouples intake from the multi-cycle back end
	ttcs_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (front_op),
		.pop     (pop),
		.head    (head_op),
		.stat    (q_stat)
	);

	// cell store, cursor and scroll/clear sequencing
	ttcs_back #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.op         (head_op),
		.op_avail   (!q_stat.empty),
		.op_pop     (pop),
		.fill_color (fill_color),
		.stat       (back_stat),
		.res_valid  (out_valid),
		.res_stall  (out_stall),
		.res_word   (out_word)
	);

	// cursor column never leaves the screen
	`TTCS_ASSERT(a_col_range, !out_valid || (out_word.cursor_col <= 7'(COLUMNS - 1)))
	// a single command never both scrolls and clears
	`TTCS_ASSERT(a_scroll_clear_excl, !(out_valid && out_word.did_scroll && out_word.did_clear))
	// the queue count stays within its depth
	`TTCS_ASSERT(a_queue_bound, q_stat.count <= Q_CNT_W'(QDEPTH))
	// a form feed always leaves the cursor at home
	`TTCS_ASSERT_IMP(a_clear_homes, out_valid && out_word.did_clear, out_word.cursor_linear == 11'd0)

endmodule

FILE: verif/text_terminal_cursor_scroll_top_tb.sv
`timescale 1ns / 1ps
// testbench for the text terminal: directed and random words checked against a cell-level predictor
module text_terminal_cursor_scroll_top_tb;
	import ttcs_pkg::*;

	localparam int COLUMNS = 80;
	localparam int ROWS    = 25;
	localparam int CELLS   = COLUMNS * ROWS;
	// rough word count, split into one directed and four random phases over four register settings
	localparam int TOTAL_WORDS = 1750;
	localparam int PHASE_WORDS = 430;
	localparam int MAX_REPORTS = 40;

	// predictor of the terminal: its own cell store, cursor and register copies,
	// plus the results it still waits for, oldest first
	class terminal_scoreboard;
		logic [15:0] cells [CELLS];
		int          cur_col;
		int          cur_row;
		logic [7:0]  fill_color;
		logic [7:0]  code_left;
		logic [7:0]  code_right;
		logic [7:0]  code_up;
		logic [7:0]  code_down;
		ttcs_out_t   awaited [$];
		int          errors;
		int          n_print, n_wrap, n_scroll, n_clear, n_read, n_move;

		function new();
			foreach (cells[i])
				cells[i] = '0;
			cur_col    = 0;
			cur_row    = 0;
			fill_color = RST_FILL;
			code_left  = RST_LEFT;
			code_right = RST_RIGHT;
			code_up    = RST_UP;
			code_down  = RST_DOWN;
			errors     = 0;
			n_print    = 0;
			n_wrap     = 0;
			n_scroll   = 0;
			n_clear    = 0;
			n_read     = 0;
			n_move     = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
			case (idx)
				REG_FILL:  fill_color = val;
				REG_LEFT:  code_left  = val;
				REG_RIGHT: code_right = val;
				REG_UP:    code_up    = val;
				REG_DOWN:  code_down  = val;
				default:   ;
			endcase
		endfunction

		function void scroll_up();
			for (int i = 0; i < CELLS - COLUMNS; i++)
				cells[i] = cells[i + COLUMNS];
			for (int i = CELLS - COLUMNS; i < CELLS; i++)
				cells[i] = {fill_color, 8'h00};
			cur_row = ROWS - 1;
			cur_col = 0;
			n_scroll++;
		endfunction

		// work out the result of one accepted input word
		function void note_word(ttcs_in_t w);
			ttcs_out_t  res;
			int         pos;
			logic [7:0] color;
			res = '0;
			if (w.cmd == CMD_READ) begin
				n_read++;
				if (w.read_col < COLUMNS && w.read_row < ROWS)
					res.read_cell = cells[w.read_row * COLUMNS + w.read_col];
			end else if (w.char_byte == CHAR_NL) begin
				cur_col = 0;
				if (cur_row < ROWS - 1)
					cur_row++;
				else begin
					scroll_up();
					res.did_scroll = 1'b1;
				end
			end else if (w.char_byte == CHAR_FF) begin
				foreach (cells[i])
					cells[i] = CLEAR_CELL;
				cur_col = 0;
				cur_row = 0;
				res.did_clear = 1'b1;
				n_clear++;
			end else if (w.char_byte == code_left) begin
				n_move++;
				if (cur_col > 0)
					cur_col--;
			end else if (w.char_byte == code_right) begin
				n_move++;
				if (cur_col < COLUMNS - 1)
					cur_col++;
			end else if (w.char_byte == code_up) begin
				n_move++;
				if (cur_row > 0)
					cur_row--;
			end else if (w.char_byte == code_down) begin
				n_move++;
				if (cur_row < ROWS - 1)
					cur_row++;
			end else begin
				n_print++;
				pos   = cur_row * COLUMNS + cur_col;
				color = w.keep_color ? cells[pos][15:8] : w.char_color;
				cells[pos] = {color, w.char_byte};
				if (cur_col < COLUMNS - 1)
					cur_col++;
				else begin
					n_wrap++;
					cur_col = 0;
					if (cur_row < ROWS - 1)
						cur_row++;
					else begin
						scroll_up();
						res.did_scroll = 1'b1;
					end
				end
			end
			res.cursor_col    = cur_col[6:0];
			res.cursor_row    = cur_row[4:0];
			res.cursor_linear = 11'(cur_row * COLUMNS + cur_col);
			awaited.push_back(res);
		endfunction

		function void report(string field, int exp_val, int act_val);
			errors++;
			if (errors <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %0h actual %0h",
					$time, field, exp_val, act_val);
		endfunction

		// compare one accepted result with the oldest expectation
		function void check_word(ttcs_out_t got);
			ttcs_out_t exp_res;
			if (awaited.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: result with none expected, expected none actual %0h",
						$time, got);
				return;
			end
			exp_res = awaited.pop_front();
			if (got.cursor_col !== exp_res.cursor_col)
				report("cursor_col", exp_res.cursor_col, got.cursor_col);
			if (got.cursor_row !== exp_res.cursor_row)
				report("cursor_row", exp_res.cursor_row, got.cursor_row);
			if (got.cursor_linear !== exp_res.cursor_linear)
				report("cursor_linear", exp_res.cursor_linear, got.cursor_linear);
			if (got.read_cell !== exp_res.read_cell)
				report("read_cell", exp_res.read_cell, got.read_cell);
			if (got.did_scroll !== exp_res.did_scroll)
				report("did_scroll", exp_res.did_scroll, got.did_scroll);
			if (got.did_clear !== exp_res.did_clear)
				report("did_clear", exp_res.did_clear, got.did_clear);
		endfunction
	endclass

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_stall;
	ttcs_in_t             in_word   = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	ttcs_out_t            out_word;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [7:0]           cfg_data  = '0;

	terminal_scoreboard sb = new();
	int words_sent     = 0;
	int send_idle_pct  = 10;
	int recv_stall_pct = 58;

	text_terminal_cursor_scroll_top #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_word  (in_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_word (out_word),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// receiver stall, redrawn every cycle at the current pressure
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// every accepted input word goes to the predictor; sampled values are the
	// ones from before the edge, since the drivers use nonblocking assignments
	always @(posedge clk) begin
		if (arst_n && in_valid && in_stall === 1'b0)
			sb.note_word(in_word);
	end

	// every accepted result is checked against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && !out_stall)
			sb.check_word(out_word);
	end

	// safety net against a hung block
	initial begin
		#20_000_000;
		$display("simulation failed");
		$finish;
	end

	// idle pattern follows progress: sender light and receiver heavy, then
	// the other way round, then full speed on both sides
	function automatic void update_pressure();
		if (words_sent < TOTAL_WORDS / 3) begin
			send_idle_pct  = 10;
			recv_stall_pct = 58;
		end else if (words_sent < 2 * TOTAL_WORDS / 3) begin
			send_idle_pct  = 58;
			recv_stall_pct = 10;
		end else begin
			send_idle_pct  = 0;
			recv_stall_pct = 0;
		end
	endfunction

	// present one word and hold it until the block takes it; valid stays high
	// into the next word unless the sender decides to idle
	task automatic send_word(input ttcs_in_t w);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_word  <= w;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
		words_sent++;
		update_pressure();
	endtask

	// lower valid and wait until every expected result is back, then keep
	// waiting so the block sits idle before the next register write
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.awaited.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// write all five registers back to back; the predictor copy is updated at
	// each handshake
	task automatic write_regs(input logic [7:0] fill, input logic [7:0] left,
			input logic [7:0] right, input logic [7:0] up, input logic [7:0] down);
		logic [7:0] vals [5];
		logic [CFG_IDX_W-1:0] idx [5];
		vals = '{fill, left, right, up, down};
		idx  = '{REG_FILL, REG_LEFT, REG_RIGHT, REG_UP, REG_DOWN};
		for (int i = 0; i < 5; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= vals[i];
			@(posedge clk);
			while (cfg_ready !== 1'b1)
				@(posedge clk);
			sb.set_reg(idx[i], vals[i]);
		end
		cfg_valid <= 1'b0;
	endtask

	// put word; the read fields ride along with random content
	function automatic ttcs_in_t put_word(logic [7:0] ch, logic [7:0] color, logic keep);
		ttcs_in_t w;
		w.cmd        = CMD_PUT;
		w.char_byte  = ch;
		w.char_color = color;
		w.keep_color = keep;
		w.read_col   = 7'($urandom_range(127));
		w.read_row   = 5'($urandom_range(31));
		return w;
	endfunction

	// read word; the put fields carry random content, control bytes included
	function automatic ttcs_in_t read_word(int col, int row);
		ttcs_in_t w;
		w.cmd        = CMD_READ;
		w.char_byte  = 8'($urandom_range(255));
		w.char_color = 8'($urandom_range(255));
		w.keep_color = 1'($urandom_range(1));
		w.read_col   = 7'(col);
		w.read_row   = 5'(row);
		return w;
	endfunction

	function automatic ttcs_in_t rand_put(logic [7:0] ch);
		return put_word(ch, 8'($urandom_range(255)), 1'($urandom_range(1)));
	endfunction

	// one of the four cursor codes as currently configured
	function automatic logic [7:0] pick_code();
		case ($urandom_range(3))
			0:       return sb.code_left;
			1:       return sb.code_right;
			2:       return sb.code_up;
			default: return sb.code_down;
		endcase
	endfunction

	// reads are mostly on screen, about one in five anywhere in the field range
	function automatic ttcs_in_t rand_read();
		if ($urandom_range(4) == 0)
			return read_word($urandom_range(127), $urandom_range(31));
		return read_word($urandom_range(COLUMNS - 1), $urandom_range(ROWS - 1));
	endfunction

	// random traffic made of segments: long lines that wrap and scroll, runs of
	// one cursor code that pin the cursor at an edge, bursts of reads, and a
	// general mix with rare form feeds
	task automatic random_words(input int count);
		int stop_at;
		int len;
		int sel;
		logic [7:0] run_code;
		stop_at = words_sent + count;
		while (words_sent < stop_at) begin
			sel = $urandom_range(9);
			if (sel <= 1) begin
				len = $urandom_range(60, 100);
				repeat (len) send_word(rand_put(8'($urandom_range(255))));
			end else if (sel == 2) begin
				// right or down repeated, often far enough to hit the edge
				run_code = $urandom_range(1) ? sb.code_right : sb.code_down;
				len = $urandom_range(5, 85);
				repeat (len) send_word(rand_put(run_code));
				repeat ($urandom_range(1, 4)) send_word(rand_put(8'($urandom_range(255))));
			end else if (sel == 3) begin
				len = $urandom_range(5, 15);
				repeat (len) send_word(rand_read());
			end else begin
				repeat (20) begin
					len = $urandom_range(99);
					if (len < 14)
						send_word(rand_put(CHAR_NL));
					else if (len < 26)
						send_word(rand_put(pick_code()));
					else if (len < 40)
						send_word(rand_read());
					else if (len < 41)
						send_word(rand_put(CHAR_FF));
					else
						send_word(rand_put(8'($urandom_range(255))));
				end
			end
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed words at the reset register values; the block holds in_stall
		// high during its clearing sweep, and send_word waits that out
		send_word(read_word(0, 0));                    // fresh store reads zero
		send_word(read_word(127, 31));                 // far outside the screen
		send_word(read_word(COLUMNS - 1, ROWS - 1));   // last cell
		send_word(read_word(COLUMNS, 0));              // column just off screen
		send_word(read_word(0, ROWS));                 // row just off screen
		send_word(put_word(sb.code_left, 8'h00, 1'b0));  // left stops at column 0
		send_word(put_word(sb.code_up, 8'hFF, 1'b1));    // up stops at row 0
		send_word(put_word(8'h41, 8'hFF, 1'b0));
		send_word(put_word(8'h00, 8'hFF, 1'b1));       // keep color of a zero cell
		send_word(put_word(8'hFF, 8'h5A, 1'b0));
		send_word(put_word(sb.code_left, 8'h00, 1'b0));
		send_word(put_word(sb.code_left, 8'h00, 1'b0));
		send_word(put_word(sb.code_left, 8'h00, 1'b0));
		send_word(put_word(8'h42, 8'h00, 1'b1));       // keeps the 0xff color
		send_word(read_word(0, 0));
		send_word(read_word(2, 0));
		send_word(put_word(sb.code_right, 8'h00, 1'b0));
		send_word(put_word(sb.code_down, 8'h00, 1'b0));
		send_word(put_word(sb.code_down, 8'h00, 1'b0));
		send_word(put_word(CHAR_NL, 8'hFF, 1'b1));
		send_word(put_word(sb.code_up, 8'h00, 1'b0));
		send_word(put_word(CHAR_FF, 8'h00, 1'b1));     // clear and home
		send_word(read_word(10, 10));                  // cleared cell
		send_word(put_word(8'h7E, 8'h00, 1'b1));       // keeps the clear color
		send_word(read_word(0, 0));
		random_words(PHASE_WORDS);
		drain();

		// extremes: zero fill, codes at 0 and 255, up and down shadowed by
		// newline and form feed
		write_regs(8'h00, 8'h00, 8'hFF, CHAR_NL, CHAR_FF);
		random_words(PHASE_WORDS);
		drain();

		// full fill color, duplicated codes so left beats right and up beats down
		write_regs(8'hFF, 8'h80, 8'h80, 8'h7F, 8'h7F);
		random_words(PHASE_WORDS);
		drain();

		// random values everywhere
		write_regs(8'($urandom_range(255)), 8'($urandom_range(255)),
			8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)));
		random_words(PHASE_WORDS);
		drain();

		if (sb.awaited.size() != 0)
			sb.errors++;
		$display("run covered %0d words: %0d prints, %0d wraps, %0d scrolls, %0d clears",
			words_sent, sb.n_print, sb.n_wrap, sb.n_scroll, sb.n_clear);
		$display("plus %0d reads and %0d cursor moves over four register settings",
			sb.n_read, sb.n_move);
		if (sb.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
